@@ rtl/sse_pkg.sv @@
`timescale 1ns / 1ps

package sse_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [6:0] CH_BSLASH = 7'h5C;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_X      = 7'h78;
    localparam logic [6:0] CH_UA     = 7'h41;

    typedef enum logic [1:0] {
        K_PLAIN = 2'd0,
        K_SHORT = 2'd1,
        K_HEX   = 2'd2
    } t_kind;

    // code holds the byte itself for plain and hex, the escape letter for short
    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

    function automatic t_entry classify(input logic [7:0] b);
        t_entry e;
        e.kind = K_SHORT;
        e.code = b;
        case (b)
            8'h07: e.code = 8'h61;
            8'h08: e.code = 8'h62;
            8'h0C: e.code = 8'h66;
            8'h0A: e.code = 8'h6E;
            8'h0D: e.code = 8'h72;
            8'h09: e.code = 8'h74;
            8'h0B: e.code = 8'h76;
            8'h27, 8'h22, 8'h3F, 8'h5C: e.code = b;
            default: begin
                if (b inside {[8'h20:8'h7E]}) begin
                    e.kind = K_PLAIN;
                end else begin
                    e.kind = K_HEX;
                end
            end
        endcase
        return e;
    endfunction

    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        logic [6:0] d;
        if (nib < 4'd10) begin
            d = CH_ZERO + {3'd0, nib};
        end else begin
            d = CH_UA + {3'd0, nib} - 7'd10;
        end
        return d;
    endfunction

endpackage

@@ rtl/c_string_escape_encoder.sv @@
// path: a byte is held in the input stage register, then a queue slot, then the output register
// throughput: one byte per cycle into a 4-word queue unless full; the output register drains
// 1, 2 or 5 characters per byte, one per cycle unless stalled, so the output port sets the rate
// reset: synchronous active low, empties the input stage, queue and output register
`timescale 1ns / 1ps

module c_string_escape_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    output logic       o_stall,
    output logic       o_valid,
    output logic [6:0] o_out_char,
    output logic       o_last_char,
    input  logic       i_stall
);

    logic                w_push;
    logic                w_pop;
    sse_pkg::t_entry     w_entry;
    sse_pkg::t_entry     w_head;
    sse_pkg::t_fifo_stat w_stat;

    sse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .o_stall     (o_stall),
        .o_push      (w_push),
        .o_entry     (w_entry),
        .i_full      (w_stat.full)
    );

    sse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    sse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_stat      (w_stat),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char),
        .i_stall     (i_stall)
    );

    // a word still in progress keeps the output fed on the next cycle
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_char && !i_stall |=> o_valid)
        else $error("gap inside an escape sequence");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_stat.empty)
        else $error("pop from empty queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not idle after reset");

endmodule

@@ rtl/sse_front.sv @@
`timescale 1ns / 1ps

module sse_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_data_byte,
    output logic            o_stall,
    output logic            o_push,
    output sse_pkg::t_entry o_entry,
    input  logic            i_full
);

    logic            r_valid;
    sse_pkg::t_entry r_entry;
    logic            n_valid;
    logic            w_take;

    assign o_push  = r_valid && !i_full;
    assign o_stall = r_valid && i_full;
    assign o_entry = r_entry;
    assign w_take  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_entry <= sse_pkg::classify(i_data_byte);
        end
    end

endmodule

@@ rtl/sse_fifo.sv @@
`timescale 1ns / 1ps

module sse_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sse_pkg::t_entry    i_entry,
    input  logic               i_pop,
    output sse_pkg::t_entry    o_head,
    output sse_pkg::t_fifo_stat o_stat
);

    sse_pkg::t_entry                  r_slot [sse_pkg::FIFO_DEPTH];
    logic [sse_pkg::FIFO_AW-1:0]      r_wp;
    logic [sse_pkg::FIFO_AW-1:0]      r_rp;
    logic [sse_pkg::FIFO_CW-1:0]      r_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == sse_pkg::FIFO_CW'(sse_pkg::FIFO_DEPTH));
    assign o_head       = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_entry;
        end
    end

endmodule

@@ rtl/sse_back.sv @@
`timescale 1ns / 1ps

module sse_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sse_pkg::t_entry     i_head,
    input  sse_pkg::t_fifo_stat i_stat,
    output logic                o_pop,
    output logic                o_valid,
    output logic [6:0]          o_out_char,
    output logic                o_last_char,
    input  logic                i_stall
);

    logic       r_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic [2:0] r_step;
    logic       n_valid;
    logic [2:0] n_step;
    logic [6:0] w_char;
    logic       w_last;
    logic       w_slot;

    // character at the current step of the word at the queue head
    always_comb begin
        w_char = sse_pkg::CH_BSLASH;
        w_last = 1'b0;
        case (i_head.kind)
            sse_pkg::K_PLAIN: begin
                w_char = i_head.code[6:0];
                w_last = 1'b1;
            end
            sse_pkg::K_SHORT: begin
                if (r_step != 3'd0) begin
                    w_char = i_head.code[6:0];
                    w_last = 1'b1;
                end
            end
            sse_pkg::K_HEX: begin
                case (r_step)
                    3'd0:    w_char = sse_pkg::CH_BSLASH;
                    3'd1:    w_char = sse_pkg::CH_ZERO;
                    3'd2:    w_char = sse_pkg::CH_X;
                    3'd3:    w_char = sse_pkg::hex_digit(i_head.code[7:4]);
                    default: begin
                        w_char = sse_pkg::hex_digit(i_head.code[3:0]);
                        w_last = 1'b1;
                    end
                endcase
            end
            default: begin
                w_char = sse_pkg::CH_BSLASH;
                w_last = 1'b1;
            end
        endcase
    end

    assign w_slot = !r_valid || !i_stall;
    assign o_pop  = w_slot && !i_stat.empty && w_last;

    always_comb begin
        n_valid = r_valid;
        n_step  = r_step;
        if (w_slot) begin
            n_valid = !i_stat.empty;
            if (!i_stat.empty) begin
                n_step = w_last ? 3'd0 : r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 3'd0;
        end else begin
            r_valid <= n_valid;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot && !i_stat.empty) begin
            r_char <= w_char;
            r_last <= w_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 90;

    typedef struct {
        logic [7:0] data;
        bit         drain_first;
    } t_feed_item;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } t_esc_char;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [6:0] o_out_char;
    logic       o_last_char;

    t_feed_item byte_feed[$];
    t_esc_char  escaped_text[$];
    t_feed_item next_item;
    t_esc_char  want;

    int bytes_sent    = 0;
    int bytes_taken   = 0;
    int total_bytes   = 0;
    int chars_checked = 0;
    int errors        = 0;
    int plain_bytes   = 0;
    int short_bytes   = 0;
    int hex_bytes     = 0;
    int stall_cycles  = 0;
    int long_holds    = 0;
    int cycle_count   = 0;

    int burst_left = 1;
    int gap_left   = 0;
    int rx_cycle   = 0;
    int hold_left  = 0;
    int rx_mode    = 0;

    c_string_escape_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char),
        .i_stall     (i_stall)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        c = (nib < 4'd10) ? 8'h30 + nib : 8'h37 + nib;
        return c[6:0];
    endfunction

    task automatic push_char(input logic [6:0] ch, input logic last);
        t_esc_char e;
        e.ch   = ch;
        e.last = last;
        escaped_text.push_back(e);
    endtask

    // expected text for one accepted byte
    task automatic escape_byte(input logic [7:0] b);
        sse_pkg::t_kind kind;
        logic [7:0]     letter;
        kind   = sse_pkg::K_SHORT;
        letter = b;
        case (b)
            8'h07: letter = "a";
            8'h08: letter = "b";
            8'h0C: letter = "f";
            8'h0A: letter = "n";
            8'h0D: letter = "r";
            8'h09: letter = "t";
            8'h0B: letter = "v";
            8'h27, 8'h22, 8'h3F, 8'h5C: letter = b;
            default: begin
                kind = (b >= 8'h20 && b <= 8'h7E) ? sse_pkg::K_PLAIN : sse_pkg::K_HEX;
            end
        endcase
        case (kind)
            sse_pkg::K_PLAIN: begin
                plain_bytes++;
                push_char(b[6:0], 1'b1);
            end
            sse_pkg::K_SHORT: begin
                short_bytes++;
                push_char(sse_pkg::CH_BSLASH, 1'b0);
                push_char(letter[6:0], 1'b1);
            end
            default: begin
                hex_bytes++;
                push_char(sse_pkg::CH_BSLASH, 1'b0);
                push_char(sse_pkg::CH_ZERO, 1'b0);
                push_char(sse_pkg::CH_X, 1'b0);
                push_char(hex_char(b[7:4]), 1'b0);
                push_char(hex_char(b[3:0]), 1'b1);
            end
        endcase
    endtask

    task automatic add_byte(input logic [7:0] b, input bit drain_first);
        t_feed_item it;
        it.data        = b;
        it.drain_first = drain_first;
        byte_feed.push_back(it);
    endtask

    // driver: bursts of words with random gaps, a drain pause where flagged
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && bytes_taken < bytes_sent) begin
                // word still stalled, hold it
            end else if (gap_left > 0) begin
                i_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (byte_feed.size() == 0 ||
                         (byte_feed[0].drain_first && escaped_text.size() != 0)) begin
                i_valid <= 1'b0;
            end else begin
                next_item = byte_feed.pop_front();
                i_valid     <= 1'b1;
                i_data_byte <= next_item.data;
                bytes_sent  <= bytes_sent + 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern, with long hold-offs to back up the queue
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (rx_cycle == 300 || rx_cycle == 900) begin
            i_stall    <= 1'b1;
            hold_left  <= LONG_HOLD;
            long_holds <= long_holds + 1;
        end else begin
            case (rx_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= 1'($urandom_range(0, 1));
                default: i_stall <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // monitor: input acceptance feeds the predictor, output words are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall) begin
                stall_cycles++;
            end
            if (i_valid && !o_stall) begin
                escape_byte(i_data_byte);
                bytes_taken <= bytes_taken + 1;
            end
            if (o_valid && !i_stall) begin
                if (escaped_text.size() == 0) begin
                    $error("unexpected output word: out_char=%h last_char=%b",
                           o_out_char, o_last_char);
                    errors++;
                end else begin
                    want = escaped_text.pop_front();
                    chars_checked++;
                    if (o_out_char !== want.ch) begin
                        $error("out_char mismatch: expected %h, got %h", want.ch, o_out_char);
                        errors++;
                    end
                    if (o_last_char !== want.last) begin
                        $error("last_char mismatch: expected %b, got %b",
                               want.last, o_last_char);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        // edges of the byte range, every short escape, delete and high bytes
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h20, 1'b0);
        add_byte(8'h7E, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h1F, 1'b0);
        add_byte(8'h07, 1'b0);
        add_byte(8'h08, 1'b0);
        add_byte(8'h0C, 1'b0);
        add_byte(8'h0A, 1'b0);
        add_byte(8'h0D, 1'b0);
        add_byte(8'h09, 1'b0);
        add_byte(8'h0B, 1'b0);
        add_byte(8'h27, 1'b0);
        add_byte(8'h22, 1'b0);
        add_byte(8'h3F, 1'b0);
        add_byte(8'h5C, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h9A, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'hAA, 1'b0);
        for (int n = 0; n < 138; n++) begin
            logic [7:0] b;
            case ($urandom_range(0, 2))
                0: b = 8'($urandom_range(8'h20, 8'h7E));
                1: begin
                    case ($urandom_range(0, 10))
                        0:       b = 8'h07;
                        1:       b = 8'h08;
                        2:       b = 8'h0C;
                        3:       b = 8'h0A;
                        4:       b = 8'h0D;
                        5:       b = 8'h09;
                        6:       b = 8'h0B;
                        7:       b = 8'h27;
                        8:       b = 8'h22;
                        9:       b = 8'h3F;
                        default: b = 8'h5C;
                    endcase
                end
                default: b = 8'($urandom_range(0, 255));
            endcase
            // sender waits for the output to drain before a few of the words
            add_byte(b, n == 0 || n == 70 || n == 130);
        end
        total_bytes = byte_feed.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken < total_bytes) @(posedge i_clk);
        while (escaped_text.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("%0d bytes escaped (%0d plain, %0d short, %0d hex), %0d chars checked",
                 total_bytes, plain_bytes, short_bytes, hex_bytes, chars_checked);
        $display("input held off in %0d cycles, %0d long output hold-offs, %0d errors",
                 stall_cycles, long_holds, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
